// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file cfr_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never hold while out of reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// ante in one cycle implies cons in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante in one cycle implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types, constants and a helper function of the command frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int DEF_COUNT_BITS  = 32;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam int NUM_FLAGS  = 9;
  localparam int FLAG_IDX_W = $clog2(NUM_FLAGS);

  // emit order of the pending acknowledge flags
  localparam logic [6:0] FLAG_CODES [NUM_FLAGS] = '{
    7'd9, 7'd10, 7'd11, 7'd61, 7'd62, 7'd13, 7'd5, 7'd6, 7'd7
  };

  localparam logic [11:0] MAG_LIMIT  = 12'd2048;
  localparam logic [6:0]  SILENT_LO  = 7'd1;
  localparam logic [6:0]  SILENT_HI  = 7'd3;
  localparam logic [7:0]  ASCII_ZERO = 8'h30;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_DATA1 = 2'd1,
    PH_DATA2 = 2'd2
  } phase_t;

  // one tick's worth of work handed from front to back
  typedef struct packed {
    logic [NUM_FLAGS-1:0] flags;
    logic [6:0]           other_id;
    logic [31:0]          byte_count;
    logic [31:0]          fail_count;
  } job_t;

  function automatic logic [31:0] ascii_digits(input logic [6:0] code);
    logic [6:0] rem;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [6:0] ones;
    hund = (code >= 7'd100) ? 4'd1 : 4'd0;
    rem  = (code >= 7'd100) ? code - 7'd100 : code;
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= 7'(k * 10)) tens = 4'(k);
    end
    ones = rem - 7'(32'(tens) * 10);
    return {ASCII_ZERO, ASCII_ZERO + 8'(hund), ASCII_ZERO + 8'(tens), ASCII_ZERO + 8'(ones)};
  endfunction

endpackage

// ===== rtl/core/cfr_front.sv =====
// ----------------------------------------------------------------------------
// cfr_front
// Frame parser: takes bytes and ticks, tracks pending acks and counters,
// and hands a snapshot job to the queue on every tick.
// ----------------------------------------------------------------------------
module cfr_front import cfr_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic [7:0] rx_byte,
  output logic       q_push,
  output job_t       q_job,
  input  logic       q_full
);

  phase_t                phase, phase_next;
  logic [6:0]            header_id, header_id_next;
  logic [6:0]            first_data, first_data_next;
  logic [NUM_FLAGS-1:0]  pending, pending_next;
  logic [6:0]            other_id, other_id_next;
  logic [COUNT_BITS-1:0] byte_cnt, byte_cnt_next;
  logic [COUNT_BITS-1:0] fail_cnt, fail_cnt_next;

  logic                  in_fire;
  logic [11:0]           mag;
  logic                  flag_hit;
  logic [FLAG_IDX_W-1:0] flag_idx;
  logic [63:0]           byte_ext;
  logic [63:0]           fail_ext;

  assign in_stall = (cmd == CMD_TICK) && q_full;
  assign in_fire  = in_valid && !in_stall;
  assign mag      = {first_data[4:0], rx_byte[6:0]};
  assign byte_ext = 64'(byte_cnt);
  assign fail_ext = 64'(fail_cnt);

  always_comb begin
    flag_hit = 1'b0;
    flag_idx = '0;
    for (int i = 0; i < NUM_FLAGS; i++) begin
      if (FLAG_CODES[i] == header_id) begin
        flag_hit = 1'b1;
        flag_idx = FLAG_IDX_W'(i);
      end
    end
  end

  always_comb begin
    phase_next      = phase;
    header_id_next  = header_id;
    first_data_next = first_data;
    pending_next    = pending;
    other_id_next   = other_id;
    byte_cnt_next   = byte_cnt;
    fail_cnt_next   = fail_cnt;
    q_push          = 1'b0;
    q_job           = '{flags: pending, other_id: other_id,
                        byte_count: byte_ext[31:0], fail_count: fail_ext[31:0]};
    if (in_fire) begin
      if (cmd == CMD_TICK) begin
        q_push        = 1'b1;
        pending_next  = '0;
        other_id_next = 7'd0;
      end else begin
        unique case (phase)
          PH_DATA1, PH_DATA2: begin
            byte_cnt_next = byte_cnt + COUNT_BITS'(1);
            if (rx_byte[7]) begin
              header_id_next = rx_byte[6:0];
              fail_cnt_next  = fail_cnt + COUNT_BITS'(1);
              phase_next     = PH_DATA1;
            end else if (phase == PH_DATA1) begin
              first_data_next = rx_byte[6:0];
              phase_next      = PH_DATA2;
            end else begin
              phase_next = PH_HUNT;
              if (mag > MAG_LIMIT) begin
                fail_cnt_next = fail_cnt + COUNT_BITS'(1);
              end else if (header_id >= SILENT_LO && header_id <= SILENT_HI) begin
                pending_next = pending;
              end else if (flag_hit) begin
                pending_next[flag_idx] = 1'b1;
              end else begin
                other_id_next = header_id;
              end
            end
          end
          default: begin
            if (rx_byte[7]) begin
              header_id_next = rx_byte[6:0];
              phase_next     = PH_DATA1;
            end else begin
              phase_next = PH_HUNT;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      header_id  <= 7'd0;
      first_data <= 7'd0;
      pending    <= '0;
      other_id   <= 7'd0;
      byte_cnt   <= '0;
      fail_cnt   <= '0;
    end else begin
      phase      <= phase_next;
      header_id  <= header_id_next;
      first_data <= first_data_next;
      pending    <= pending_next;
      other_id   <= other_id_next;
      byte_cnt   <= byte_cnt_next;
      fail_cnt   <= fail_cnt_next;
    end
  end

endmodule

// ===== rtl/core/cfr_queue.sv =====
// ----------------------------------------------------------------------------
// cfr_queue
// Small FIFO of tick jobs between the parser and the emitter.
// DEPTH is a power of two, at least 2.
// ----------------------------------------------------------------------------
module cfr_queue import cfr_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head_job,
  output logic not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + PTR_W'(1);
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/cfr_back.sv =====
// ----------------------------------------------------------------------------
// cfr_back
// Emitter: walks one tick job, one ack word per cycle while not stalled, in
// fixed order, then the closing status word, via a registered output stage.
// ----------------------------------------------------------------------------
module cfr_back import cfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  job_t        q_job,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_ack,
  output logic [6:0]  ack_code,
  output logic [31:0] ack_digits,
  output logic [31:0] byte_count,
  output logic [31:0] fail_count,
  output logic        last
);

  logic                  job_valid;
  job_t                  job, job_next;
  logic                  any_flag;
  logic [FLAG_IDX_W-1:0] sel;
  logic                  item_ack;
  logic [6:0]            item_code;
  logic                  load;

  always_comb begin
    any_flag = |job.flags;
    sel      = '0;
    for (int i = NUM_FLAGS - 1; i >= 0; i--) begin
      if (job.flags[i]) sel = FLAG_IDX_W'(i);
    end
  end

  always_comb begin
    job_next = job;
    if (any_flag) begin
      item_ack           = 1'b1;
      item_code          = FLAG_CODES[sel];
      job_next.flags[sel] = 1'b0;
    end else if (job.other_id != 7'd0) begin
      item_ack          = 1'b1;
      item_code         = job.other_id;
      job_next.other_id = 7'd0;
    end else begin
      item_ack  = 1'b0;
      item_code = 7'd0;
    end
  end

  assign load  = job_valid && (!out_valid || !out_stall);
  assign q_pop = q_valid && (!job_valid || (load && !item_ack));

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        job_valid <= 1'b1;
      end else if (load && !item_ack) begin
        job_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end else if (load) begin
      job <= job_next;
    end
    if (load) begin
      is_ack     <= item_ack;
      ack_code   <= item_code;
      ack_digits <= item_ack ? ascii_digits(item_code) : 32'd0;
      byte_count <= item_ack ? 32'd0 : job.byte_count;
      fail_count <= item_ack ? 32'd0 : job.fail_count;
      last       <= !item_ack;
    end
  end

endmodule

// ===== rtl/core/command_frame_receiver_with_acks.sv =====
// ----------------------------------------------------------------------------
// command_frame_receiver_with_acks
// Serial command frame receiver that answers each tick with acks and status.
//
// Input channel (in_valid / in_stall): one word per cycle, cmd = 0 carries a
// received byte in rx_byte, cmd = 1 is a notify tick. Byte words are never
// stalled; a tick stalls only while the job queue (QUEUE_DEPTH ticks) is full.
// Output channel (out_valid / out_stall): each tick yields its pending ack
// words in fixed order, then one status word with last = 1 that carries the
// data byte and failure counters as they stood at the tick.
// A tick's words pass through the job queue, the emitter's job register and
// the registered output stage; the emitter then sends one word per cycle
// while not stalled, so a tick yields one to eleven output words.
// A stalled output word holds; the emitter and queue keep the parser free,
// so bytes are still taken while the receiver stalls.
// Reset clears the parser, pending acks, counters, queue and output stage.
// ----------------------------------------------------------------------------
module command_frame_receiver_with_acks import cfr_pkg::*; #(
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_ack,
  output logic [6:0]  ack_code,
  output logic [31:0] ack_digits,
  output logic [31:0] byte_count,
  output logic [31:0] fail_count,
  output logic        last
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_not_empty;
  job_t push_job;
  job_t head_job;

  cfr_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd     (cmd),
    .rx_byte (rx_byte),
    .q_push  (q_push),
    .q_job   (push_job),
    .q_full  (q_full)
  );

  cfr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (head_job),
    .not_empty(q_not_empty)
  );

  cfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_ack    (is_ack),
    .ack_code  (ack_code),
    .ack_digits(ack_digits),
    .byte_count(byte_count),
    .fail_count(fail_count),
    .last      (last)
  );

endmodule

// ===== rtl/core/cfr_checker.sv =====
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks of the command frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        cmd,
  input logic [7:0]  rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic        is_ack,
  input logic [6:0]  ack_code,
  input logic [31:0] ack_digits,
  input logic [31:0] byte_count,
  input logic [31:0] fail_count,
  input logic        last
);

  `ASSERT_NEVER(a_byte_never_stalled, clk, rst, !cmd && in_stall, "byte word stalled")
  `ASSERT_IMPL(a_status_shape, clk, rst, out_valid && last, !is_ack && ack_code == 7'd0 && ack_digits == 32'd0, "bad status word")
  `ASSERT_IMPL(a_ack_shape, clk, rst, out_valid && is_ack, !last && ack_code != 7'd0 && ack_digits[31:24] == 8'h30 && byte_count == 32'd0 && fail_count == 32'd0, "bad ack word")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(ack_code) && $stable(last) && $stable(fail_count), "stalled word changed")

endmodule

bind command_frame_receiver_with_acks cfr_checker u_cfr_checker (.*);

// ===== verif/cfr_ack_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_ack_checker
// Watches both channels of the command frame receiver, tracks frame parsing,
// pending acks and counters on every accepted input word, and compares each
// accepted output word against the oldest predicted reply word.
// ----------------------------------------------------------------------------
module cfr_ack_checker import cfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        is_ack,
  input  logic [6:0]  ack_code,
  input  logic [31:0] ack_digits,
  input  logic [31:0] byte_count,
  input  logic [31:0] fail_count,
  input  logic        last,
  output int          mismatches,
  output int          outstanding
);

  typedef struct {
    logic        is_ack;
    logic [6:0]  code;
    logic [31:0] digits;
    logic [31:0] bytes;
    logic [31:0] fails;
    logic        last;
  } reply_t;

  localparam int          ACK_SLOTS     = 9;
  localparam logic [11:0] MAX_MAGNITUDE = 12'd2048;
  localparam logic [6:0]  ACK_ORDER [ACK_SLOTS] = '{
    7'd9, 7'd10, 7'd11, 7'd61, 7'd62, 7'd13, 7'd5, 7'd6, 7'd7
  };

  phase_t               phase;
  logic [6:0]           hdr_id;
  logic [6:0]           data1;
  logic [ACK_SLOTS-1:0] ack_flags;
  logic [6:0]           other_id;
  logic [31:0]          nbytes;
  logic [31:0]          nfails;
  reply_t               reply_q[$];
  int                   tally;

  initial begin
    tally = 0;
  end

  function automatic logic [31:0] code_text(input logic [6:0] c);
    int v;
    v = c;
    return {8'h30, 8'h30 + 8'(v / 100), 8'h30 + 8'((v / 10) % 10), 8'h30 + 8'(v % 10)};
  endfunction

  function automatic void raise_ack(input logic [6:0] id);
    if (id >= 7'd1 && id <= 7'd3) return;
    for (int i = 0; i < ACK_SLOTS; i++) begin
      if (ACK_ORDER[i] == id) begin
        ack_flags[i] = 1'b1;
        return;
      end
    end
    other_id = id;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    logic [11:0] mag;
    if (phase == PH_DATA1 || phase == PH_DATA2) begin
      nbytes = nbytes + 32'd1;
      if (b[7]) begin
        hdr_id = b[6:0];
        nfails = nfails + 32'd1;
        phase  = PH_DATA1;
      end else if (phase == PH_DATA1) begin
        data1 = b[6:0];
        phase = PH_DATA2;
      end else begin
        mag = {data1[4:0], b[6:0]};
        if (mag > MAX_MAGNITUDE) nfails = nfails + 32'd1;
        else raise_ack(hdr_id);
        phase = PH_HUNT;
      end
    end else if (b[7]) begin
      hdr_id = b[6:0];
      phase  = PH_DATA1;
    end else begin
      phase = PH_HUNT;
    end
  endfunction

  function automatic void queue_tick_reply();
    for (int i = 0; i < ACK_SLOTS; i++) begin
      if (ack_flags[i])
        reply_q.push_back('{1'b1, ACK_ORDER[i], code_text(ACK_ORDER[i]), 32'd0, 32'd0, 1'b0});
    end
    ack_flags = '0;
    if (other_id != 7'd0) begin
      reply_q.push_back('{1'b1, other_id, code_text(other_id), 32'd0, 32'd0, 1'b0});
      other_id = 7'd0;
    end
    reply_q.push_back('{1'b0, 7'd0, 32'd0, nbytes, nfails, 1'b1});
  endfunction

  always @(posedge clk) begin : watch
    reply_t w;
    if (rst) begin
      phase     = PH_HUNT;
      hdr_id    = '0;
      data1     = '0;
      ack_flags = '0;
      other_id  = '0;
      nbytes    = '0;
      nfails    = '0;
      reply_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (cmd == CMD_TICK) queue_tick_reply();
        else absorb_byte(rx_byte);
      end
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          tally++;
          if (tally <= 10)
            $display("%0t: unexpected word ack=%0b code=%0d digits=%h %s=%0d %s=%0d last=%0b",
                     $time, is_ack, ack_code, ack_digits, "bytes", byte_count,
                     "fails", fail_count, last);
        end else begin
          w = reply_q.pop_front();
          if (w.is_ack !== is_ack || w.code !== ack_code || w.digits !== ack_digits ||
              w.bytes !== byte_count || w.fails !== fail_count || w.last !== last) begin
            tally++;
            if (tally <= 10) begin
              $display("%0t: word mismatch", $time);
              $display("  exp ack=%0b code=%0d digits=%h bytes=%0d fails=%0d last=%0b",
                       w.is_ack, w.code, w.digits, w.bytes, w.fails, w.last);
              $display("  got ack=%0b code=%0d digits=%h bytes=%0d fails=%0d last=%0b",
                       is_ack, ack_code, ack_digits, byte_count, fail_count, last);
            end
          end
        end
      end
    end
    mismatches  <= tally;
    outstanding <= reply_q.size();
  end

endmodule

// ===== verif/command_frame_receiver_with_acks_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_receiver_with_acks_tb
// Drives serial bytes and notify ticks into the frame receiver: a directed
// pass over edge cases, then random frames, broken frames and noise, with
// random idle bursts on both channels. Checking is done by cfr_ack_checker.
// ----------------------------------------------------------------------------
module command_frame_receiver_with_acks_tb import cfr_pkg::*; ();

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = CMD_BYTE;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_ack;
  logic [6:0]  ack_code;
  logic [31:0] ack_digits;
  logic [31:0] byte_count;
  logic [31:0] fail_count;
  logic        last;
  int          mismatches;
  int          outstanding;

  bit calm = 1'b0;
  int sent = 0;

  localparam logic [6:0] ACK_IDS [9] = '{
    7'd5, 7'd6, 7'd7, 7'd9, 7'd10, 7'd11, 7'd13, 7'd61, 7'd62
  };

  command_frame_receiver_with_acks DUT (.*);

  cfr_ack_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  // receiver back-pressure bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic c, input logic [7:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_frame(input logic [6:0] id, input logic [7:0] d1, input logic [7:0] d2);
    send_word(CMD_BYTE, {1'b1, id});
    send_word(CMD_BYTE, d1);
    if ($urandom_range(0, 9) == 0) send_word(CMD_TICK, 8'($urandom));
    send_word(CMD_BYTE, d2);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int         pick;
    logic [6:0] id;
    logic [4:0] lo;
    bit         paused;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_word(CMD_TICK, 8'h00);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h7F);
    send_word(CMD_BYTE, 8'h85);
    send_word(CMD_BYTE, 8'h10);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'hE4);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h05);
    send_word(CMD_BYTE, 8'h89);
    send_word(CMD_BYTE, 8'hBD);
    send_word(CMD_BYTE, 8'h20);
    send_word(CMD_BYTE, 8'h01);
    send_word(CMD_TICK, 8'hFF);
    send_word(CMD_BYTE, 8'hFF);
    send_word(CMD_BYTE, 8'h3F);
    send_word(CMD_BYTE, 8'h7F);
    send_word(CMD_BYTE, 8'h87);
    send_word(CMD_TICK, 8'h00);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h8A);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'hBE);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h00);
    send_frame(7'd1, 8'h10, 8'h01);
    send_frame(7'd2, 8'h00, 8'h00);
    send_frame(7'd63, 8'h00, 8'h00);
    send_frame(7'd0, 8'h00, 8'h00);
    send_word(CMD_TICK, 8'h00);
    wait_drained();

    sent = 0;
    while (sent < 200) begin
      if (sent >= 100 && !paused) begin
        wait_drained();
        paused = 1'b1;
      end
      calm = (sent >= 160);
      pick = $urandom_range(0, 99);
      id   = ($urandom_range(0, 1) == 0) ? ACK_IDS[$urandom_range(0, 8)] : 7'($urandom);
      lo   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
      if (pick < 16) begin
        send_word(CMD_TICK, 8'($urandom));
      end else if (pick < 24) begin
        send_word(CMD_BYTE, {1'b0, 7'($urandom)});
        sent--;
      end else if (pick < 32) begin
        send_word(CMD_BYTE, {1'b1, id});
        if ($urandom_range(0, 1) == 0) send_word(CMD_BYTE, {1'b0, 7'($urandom)});
        send_word(CMD_BYTE, {1'b1, 7'($urandom)});
      end else begin
        send_frame(id, {1'b0, 2'($urandom), lo}, {1'b0, 7'($urandom)});
      end
    end
    send_word(CMD_TICK, 8'h00);
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
